// ----- sv/wcc_pkg.sv -----
// wcc_pkg: shared types and constants of the window co-occurrence counter
// op codes, controller state, response select and the command/status structs
// no dependencies
package wcc_pkg;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int VALUE_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_TOKEN = 2'd0,
      OP_PAIR  = 2'd1,
      OP_MENT  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_PAIR,
      SEL_MENT
   } sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_POP_IDX,
      ST_MENT_WR,
      ST_CHECK,
      ST_PAIR_B,
      ST_PAIR_WB,
      ST_FINISH,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic    ready;
      logic    clear_step;
      logic    token_write;
      logic    slot_rd_oldest;
      logic    pop_latch;
      logic    ment_wr;
      logic    scan_start;
      logic    scan_next;
      logic    pair_rd_a;
      logic    pair_wr_a;
      logic    pair_rd_b;
      logic    pair_wr_b;
      logic    pop_finish;
      logic    read_pair;
      logic    read_ment;
      logic    load_rsp;
      sel_type rsp_sel;
      logic    rsp_popped;
   } cmd_type;

   typedef struct packed {
      logic            req_valid;
      logic [OP_W-1:0] op;
      logic            ni_ok;
      logic            pair_ok;
      logic            full;
      logic            oldest_valid;
      logic            hit;
      logic            scan_last;
      logic            clear_last;
      logic            out_busy;
   } status_type;

endpackage

// ----- sv/wcc_if.sv -----
// wcc_req_if / wcc_rsp_if: valid/ready channels of the co-occurrence counter
// depends on wcc_pkg for field widths
interface wcc_req_if;
   import wcc_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic               is_name;
   logic [IDX_W-1:0]   name_index;
   logic [IDX_W-1:0]   other_index;

   modport source (output valid, op, is_name, name_index, other_index, input ready);
   modport sink   (input valid, op, is_name, name_index, other_index, output ready);
endinterface

interface wcc_rsp_if;
   import wcc_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] read_value;
   logic               popped;

   modport source (output valid, read_value, popped, input ready);
   modport sink   (input valid, read_value, popped, output ready);
endinterface

// ----- sv/wcc_ctrl.sv -----
// wcc_ctrl: sequencer of the co-occurrence counter
// drives the datapath by wcc_pkg::cmd_type, reads wcc_pkg::status_type
module wcc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  wcc_pkg::status_type st,
   output wcc_pkg::cmd_type    cmd
);
   import wcc_pkg::*;

   state_type state_ff, state_in;
   sel_type   sel_ff, sel_in;
   logic      popped_ff, popped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         sel_ff    <= SEL_ZERO;
         popped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         popped_ff <= popped_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (st.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (st.req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (st.op)
               OP_TOKEN: begin
                  if (!st.full)             state_in = ST_RESP;
                  else if (st.oldest_valid) state_in = ST_POP_IDX;
                  else                      state_in = ST_FINISH;
               end
               OP_PAIR: state_in = st.pair_ok ? ST_RD_WAIT : ST_RESP;
               OP_MENT: state_in = st.ni_ok ? ST_RD_WAIT : ST_RESP;
               default: state_in = ST_RESP;
            endcase
         end
         ST_POP_IDX: state_in = ST_MENT_WR;
         ST_MENT_WR: state_in = ST_CHECK;
         ST_CHECK: begin
            if (st.hit)            state_in = ST_PAIR_B;
            else if (st.scan_last) state_in = ST_FINISH;
         end
         ST_PAIR_B: state_in = ST_PAIR_WB;
         ST_PAIR_WB: state_in = st.scan_last ? ST_FINISH : ST_CHECK;
         ST_FINISH: state_in = ST_RESP;
         ST_RD_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (!st.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      sel_in         = sel_ff;
      popped_in      = popped_ff;
      cmd.rsp_sel    = sel_ff;
      cmd.rsp_popped = popped_ff;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE:  cmd.ready = 1'b1;
         ST_EXEC: begin
            sel_in    = SEL_ZERO;
            popped_in = 1'b0;
            case (st.op)
               OP_TOKEN: begin
                  cmd.token_write = 1'b1;
                  if (st.full && st.oldest_valid) cmd.slot_rd_oldest = 1'b1;
               end
               OP_PAIR: begin
                  if (st.pair_ok) begin
                     cmd.read_pair = 1'b1;
                     sel_in        = SEL_PAIR;
                  end
               end
               OP_MENT: begin
                  if (st.ni_ok) begin
                     cmd.read_ment = 1'b1;
                     sel_in        = SEL_MENT;
                  end
               end
               default: sel_in = SEL_ZERO;
            endcase
         end
         ST_POP_IDX: cmd.pop_latch = 1'b1;
         ST_MENT_WR: begin
            cmd.ment_wr    = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_CHECK: begin
            if (st.hit)             cmd.pair_rd_a = 1'b1;
            else if (!st.scan_last) cmd.scan_next = 1'b1;
         end
         ST_PAIR_B: begin
            cmd.pair_wr_a = 1'b1;
            cmd.pair_rd_b = 1'b1;
         end
         ST_PAIR_WB: begin
            cmd.pair_wr_b = 1'b1;
            if (!st.scan_last) cmd.scan_next = 1'b1;
         end
         ST_FINISH: begin
            cmd.pop_finish = 1'b1;
            sel_in         = SEL_ZERO;
            popped_in      = 1'b1;
         end
         ST_RD_WAIT: cmd.ready = 1'b0;
         ST_RESP: begin
            if (!st.out_busy) cmd.load_rsp = 1'b1;
         end
         default: cmd.ready = 1'b0;
      endcase
   end

endmodule

// ----- sv/wcc_datapath.sv -----
// wcc_datapath: window ring, pair weight and mention memories, output register
// depends on wcc_pkg, wcc_req_if and wcc_rsp_if; steered by wcc_ctrl
module wcc_datapath #(
   parameter int WINDOW = 15,
   parameter int NAMES  = 64
) (
   input  logic                clock,
   input  logic                reset,
   wcc_req_if.sink             req,
   wcc_rsp_if.source           rsp,
   input  wcc_pkg::cmd_type    cmd,
   output wcc_pkg::status_type st
);
   import wcc_pkg::*;

   localparam int PW = $clog2(WINDOW);
   localparam int IW = $clog2(NAMES);
   localparam int AW = 2 * IW;
   localparam logic [PW-1:0] LAST_SLOT = PW'(WINDOW - 1);
   localparam logic [31:0]   NAMES_U   = 32'(NAMES);

   // captured request
   logic [OP_W-1:0]  req_op_ff;
   logic             req_is_name_ff;
   logic [IDX_W-1:0] req_ni_ff;
   logic [IDX_W-1:0] req_oi_ff;

   // ring
   logic [PW-1:0]    wp_ff, rp_ff, scan_ff;
   logic [WINDOW-1:0] slot_valid_ff;
   logic [IDX_W-1:0] slot_mem [WINDOW];
   logic [IDX_W-1:0] slot_rdata_ff;
   logic [PW-1:0]    w_next, rp_inc, scan_inc, slot_raddr;
   logic             slot_re;

   // counters
   logic [IW-1:0]      p_ff, q;
   logic [VALUE_W-1:0] pair_mem [2**AW];
   logic [VALUE_W-1:0] ment_mem [2**IW];
   logic [VALUE_W-1:0] pair_rdata_ff, ment_rdata_ff, pair_inc, ment_inc;
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      pair_raddr, pair_waddr;
   logic [VALUE_W-1:0] pair_wdata, ment_wdata;
   logic [IW-1:0]      ment_raddr, ment_waddr;
   logic               pair_re, pair_we, ment_re, ment_we;
   logic               ni_ok, oi_ok;

   // output register
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_popped_ff;

   wire capture = req.valid & cmd.ready;

   always_ff @(posedge clock) begin
      if (capture) begin
         req_op_ff      <= req.op;
         req_is_name_ff <= req.is_name;
         req_ni_ff      <= req.name_index;
         req_oi_ff      <= req.other_index;
      end
   end

   assign ni_ok = 32'(req_ni_ff) < NAMES_U;
   assign oi_ok = 32'(req_oi_ff) < NAMES_U;

   assign w_next   = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
   assign rp_inc   = (rp_ff == LAST_SLOT) ? '0 : rp_ff + 1'b1;
   assign scan_inc = (scan_ff == LAST_SLOT) ? '0 : scan_ff + 1'b1;
   assign q        = IW'(slot_rdata_ff);

   // ring pointers and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         rp_ff         <= '0;
         slot_valid_ff <= '0;
      end else begin
         if (cmd.token_write) begin
            wp_ff                 <= w_next;
            slot_valid_ff[w_next] <= req_is_name_ff & ni_ok;
         end
         if (cmd.pop_finish) begin
            slot_valid_ff[rp_ff] <= 1'b0;
            rp_ff                <= rp_inc;
         end
      end
   end

   // slot index memory, one write and one registered read port
   assign slot_re    = cmd.slot_rd_oldest | cmd.scan_start | cmd.scan_next;
   assign slot_raddr = cmd.slot_rd_oldest ? rp_ff : (cmd.scan_start ? '0 : scan_inc);

   always_ff @(posedge clock) begin
      if (cmd.token_write) slot_mem[w_next] <= req_ni_ff;
      if (slot_re)         slot_rdata_ff    <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start)     scan_ff <= '0;
      else if (cmd.scan_next) scan_ff <= scan_inc;
      if (cmd.pop_latch)      p_ff    <= q;
   end

   // clearing sweep over both counter memories
   always_ff @(posedge clock) begin
      if (reset)               clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end

   // saturating increments
   assign pair_inc = (&pair_rdata_ff) ? pair_rdata_ff : pair_rdata_ff + 1'b1;
   assign ment_inc = (&ment_rdata_ff) ? ment_rdata_ff : ment_rdata_ff + 1'b1;

   // pair weight memory: row is the first index
   assign pair_re    = cmd.pair_rd_a | cmd.pair_rd_b | cmd.read_pair;
   assign pair_raddr = cmd.pair_rd_a ? {q, p_ff} :
                       (cmd.pair_rd_b ? {p_ff, q} : {IW'(req_ni_ff), IW'(req_oi_ff)});
   assign pair_we    = cmd.clear_step | cmd.pair_wr_a | cmd.pair_wr_b;
   assign pair_waddr = cmd.clear_step ? clr_ff : (cmd.pair_wr_a ? {q, p_ff} : {p_ff, q});
   assign pair_wdata = cmd.clear_step ? '0 : pair_inc;

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
      if (pair_re) pair_rdata_ff        <= pair_mem[pair_raddr];
   end

   // mention memory, cleared to one during the first row of the sweep
   assign ment_re    = cmd.pop_latch | cmd.read_ment;
   assign ment_raddr = cmd.pop_latch ? q : IW'(req_ni_ff);
   assign ment_we    = cmd.ment_wr | (cmd.clear_step & (clr_ff[AW-1:IW] == '0));
   assign ment_waddr = cmd.clear_step ? clr_ff[IW-1:0] : p_ff;
   assign ment_wdata = cmd.clear_step ? VALUE_W'(1) : ment_inc;

   always_ff @(posedge clock) begin
      if (ment_we) ment_mem[ment_waddr] <= ment_wdata;
      if (ment_re) ment_rdata_ff        <= ment_mem[ment_raddr];
   end

   // output register
   always_comb begin
      case (cmd.rsp_sel)
         SEL_PAIR: rsp_value_in = pair_rdata_ff;
         SEL_MENT: rsp_value_in = ment_rdata_ff;
         default:  rsp_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.load_rsp)  rsp_valid_ff <= 1'b1;
      else if (rsp.ready)     rsp_valid_ff <= 1'b0;
      if (cmd.load_rsp) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_popped_ff <= cmd.rsp_popped;
      end
   end

   assign req.ready      = cmd.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = rsp_value_ff;
   assign rsp.popped     = rsp_popped_ff;

   // status back to the sequencer
   assign st.req_valid    = req.valid;
   assign st.op           = req_op_ff;
   assign st.ni_ok        = ni_ok;
   assign st.pair_ok      = ni_ok & oi_ok;
   assign st.full         = (({1'b0, w_next} + (PW+1)'(1)) == {1'b0, rp_ff}) ||
                            ((w_next == LAST_SLOT) && (rp_ff == '0));
   assign st.oldest_valid = slot_valid_ff[rp_ff];
   assign st.hit          = slot_valid_ff[scan_ff] & (q != p_ff);
   assign st.scan_last    = scan_ff == LAST_SLOT;
   assign st.clear_last   = &clr_ff;
   assign st.out_busy     = rsp_valid_ff & ~rsp.ready;

   // a popped slot must hold a name
   ap_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_latch |-> slot_valid_ff[rp_ff])
      else $error("pop of an empty slot reached the mention update");

   // the two symmetric weights of one pair never share an address
   ap_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_rd_a |-> (q != p_ff))
      else $error("pair update with equal indexes");

   // no result loaded over one still waiting
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && !rsp.ready))
      else $error("result register overwritten");

   // nothing is accepted or answered during the clearing sweep
   ap_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> (!rsp_valid_ff && !cmd.ready))
      else $error("activity during clearing sweep");

endmodule

// ----- sv/window_cooccurrence_counter_top.sv -----
// window_cooccurrence_counter_top: sliding-window name co-occurrence counter
// usage:
//  - req channel: one beat per item; op selects word token, pair weight read or
//    mention count read; name matching is done upstream
//  - rsp channel: exactly one beat per request, in request order
//  - a token that pops a name scans every slot of the ring and does two
//    read-modify-writes of the pair weight memory per co-occurring slot, through
//    its one write port and one registered read port
//  - one item is processed at a time; req.ready is high only when idle, and
//    the next beat is taken while a finished result still waits in the
//    output register
//  - a stalled receiver holds the result register; the item in flight waits
//    before its own result is loaded
//  - reset: ring emptied, then a clearing sweep over every pair weight address
//    zeroes pair weights and sets mentions to one; no beat is accepted during
//    the sweep
//  - counts saturate at all ones; the ring tail is never flushed
module window_cooccurrence_counter_top #(
   parameter int WINDOW = 15,
   parameter int NAMES  = 64
) (
   input  logic      clock,
   input  logic      reset,
   wcc_req_if.sink   req,
   wcc_rsp_if.source rsp
);
   import wcc_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type st;

   // sequencer: clearing sweep, token/pop/scan steps, result hand-off
   wcc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   // datapath: ring of slots, counter memories, output register
   wcc_datapath #(
      .WINDOW (WINDOW),
      .NAMES  (NAMES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (cmd),
      .st    (st)
   );

endmodule
